### rtl/core/jrsc_pkg.sv
//------------------------------------------------------------------------------
// jrsc_pkg
// Types, constants and the byte-wise CRC-32 step for the journal checker.
//------------------------------------------------------------------------------
package jrsc_pkg;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_RECORD = 2'd1,
    PH_DROP   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    RK_HEADER  = 2'd0,
    RK_RECORD  = 2'd1,
    RK_SUMMARY = 2'd2,
    RK_ERROR   = 2'd3
  } res_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_SHORT_HDR  = 3'd1,
    ERR_BAD_HDR    = 3'd2,
    ERR_BAD_CAP    = 3'd3,
    ERR_REC_CRC    = 3'd4,
    ERR_SEQ_GAP    = 3'd5,
    ERR_BAD_ENCODE = 3'd6
  } err_code_t;

  typedef struct packed {
    res_kind_t   kind;
    err_code_t   err;
    logic [63:0] record_number;
    logic [63:0] account;
    logic [63:0] client_sequence;
    logic [2:0]  command_kind;
    logic [1:0]  command_side;
    logic [63:0] order_id;
    logic [63:0] price_bits;
    logic [63:0] quantity;
    logic [19:0] capacity;
    logic [5:0]  tail_bytes;
  } res_t;

  localparam logic [31:0] CRC_INIT = 32'hffff_ffff;
  localparam logic [31:0] CRC_POLY = 32'hedb8_8320;

  // "MRDNJNL2", first byte in the low lane
  localparam logic [63:0] JRNL_MAGIC = 64'h324c_4e4a_4e44_524d;
  localparam logic [7:0]  HDR_VERSION = 8'd2;
  localparam logic [19:0] MAX_CAPACITY = 20'd1000000;

  localparam logic [5:0] HDR_LEN     = 6'd32;
  localparam logic [5:0] REC_LEN     = 6'd60;
  localparam logic [5:0] HDR_CRC_LEN = 6'd28;
  localparam logic [5:0] REC_CRC_LEN = 6'd56;

  // header byte offsets
  localparam logic [5:0] HP_VER  = 6'd8;
  localparam logic [5:0] HP_CAP  = 6'd12;
  localparam logic [5:0] HP_CFG  = 6'd20;
  localparam logic [5:0] HP_LAST = 6'd31;

  // record byte offsets
  localparam logic [5:0] RP_ACCT  = 6'd8;
  localparam logic [5:0] RP_CSEQ  = 6'd16;
  localparam logic [5:0] RP_KIND  = 6'd24;
  localparam logic [5:0] RP_SIDE  = 6'd25;
  localparam logic [5:0] RP_PAD   = 6'd26;
  localparam logic [5:0] RP_ORDER = 6'd32;
  localparam logic [5:0] RP_PRICE = 6'd40;
  localparam logic [5:0] RP_QTY   = 6'd48;
  localparam logic [5:0] RP_LAST  = 6'd59;

  localparam logic [7:0] KIND_MIN = 8'd1;
  localparam logic [7:0] KIND_MAX = 8'd4;
  localparam logic [7:0] SIDE_BUY  = 8'd1;
  localparam logic [7:0] SIDE_SELL = 8'd2;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      x = (x >> 1) ^ (CRC_POLY & {32{x[0]}});
    end
    return x;
  endfunction

endpackage

### rtl/core/journal_record_stream_checker_core.sv
//------------------------------------------------------------------------------
// journal_record_stream_checker_core
// Byte-stream checker for a journal: header check, record decode, end summary.
//------------------------------------------------------------------------------
// Takes one journal byte per cycle while in_stall is low and keeps no byte buffer:
// the header and record fields are assembled in place and the CRC, sequence and
// encoding checks are folded byte by byte, and the closing byte of a header or
// record produces its result directly into a three-entry output queue.
// Input stall rises while two or more results wait in that queue; a single
// result per item with the output draining every cycle keeps the rate at one
// item per cycle. The closing byte of a header or record that is also the last
// byte of the stream yields two results (the result and the end summary).
module journal_record_stream_checker_core (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_stream,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [2:0]  out_error_code,
  output logic [63:0] out_record_number,
  output logic [63:0] out_account,
  output logic [63:0] out_client_sequence,
  output logic [2:0]  out_command_kind,
  output logic [1:0]  out_command_side,
  output logic [63:0] out_order_id,
  output logic [63:0] out_price_bits,
  output logic [63:0] out_quantity,
  output logic [19:0] out_journal_capacity,
  output logic [5:0]  out_tail_bytes
);

  import jrsc_pkg::*;

  localparam logic [2:0] QDEPTH = 3'd3;

  function automatic logic [1:0] q_add(input logic [1:0] a, input logic [1:0] d);
    logic [2:0] s;
    s = {1'b0, a} + {1'b0, d};
    if (s >= QDEPTH) begin
      s = s - QDEPTH;
    end
    return s[1:0];
  endfunction

  // control state
  phase_t      phase_r, phase_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [63:0] good_r, good_nxt;

  // field assembly and running checks
  logic [63:0] acct_r, acct_nxt;
  logic [63:0] cseq_r, cseq_nxt;
  logic [63:0] order_r, order_nxt;
  logic [63:0] price_r, price_nxt;
  logic [63:0] qty_r, qty_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [1:0]  side_r, side_nxt;
  logic [19:0] cap_r, cap_nxt;
  logic        cap_hi_r, cap_hi_nxt;
  logic        hbad_r, hbad_nxt;
  logic        seqbad_r, seqbad_nxt;
  logic        encbad_r, encbad_nxt;
  logic        crcbad_r, crcbad_nxt;

  // output queue
  res_t        q_r [3];
  logic [1:0]  head_r, head_nxt;
  logic [1:0]  count_r, count_nxt;

  logic        accept, pop;
  logic [7:0]  b;
  logic [31:0] crc_out;
  logic [63:0] good_inc;
  logic [5:0]  pos_inc;
  logic [5:0]  cap_idx;
  logic        cap_bad;
  err_code_t   err;
  logic        main_vld, tail_vld, do_restart;
  res_t        main_res, tail_res, res0, res1;
  logic [1:0]  n_push;
  logic [1:0]  wr0, wr1;
  res_t        head_res;

  assign in_stall  = (count_r >= 2'd2);
  assign accept    = in_valid && !in_stall;
  assign out_valid = (count_r != 2'd0);
  assign pop       = out_valid && !out_stall;

  assign b        = in_data_byte;
  assign crc_out  = ~crc_r;
  assign good_inc = good_r + 64'd1;
  assign pos_inc  = pos_r + 6'd1;
  assign cap_idx  = pos_r - HP_CAP;
  assign cap_bad  = cap_hi_r || (cap_r == '0) || (cap_r > MAX_CAPACITY);

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    good_nxt   = good_r;
    acct_nxt   = acct_r;
    cseq_nxt   = cseq_r;
    order_nxt  = order_r;
    price_nxt  = price_r;
    qty_nxt    = qty_r;
    kind_nxt   = kind_r;
    side_nxt   = side_r;
    cap_nxt    = cap_r;
    cap_hi_nxt = cap_hi_r;
    hbad_nxt   = hbad_r;
    seqbad_nxt = seqbad_r;
    encbad_nxt = encbad_r;
    crcbad_nxt = crcbad_r;
    err        = ERR_NONE;
    main_vld   = 1'b0;
    tail_vld   = 1'b0;
    do_restart = 1'b0;
    main_res   = '0;
    tail_res   = '0;

    if (accept) begin
      unique case (phase_r)
        PH_DROP: begin
          if (in_end_of_stream) begin
            do_restart = 1'b1;
          end
        end

        PH_HEADER: begin
          if (pos_r == '0) begin
            hbad_nxt   = 1'b0;
            cap_hi_nxt = 1'b0;
          end
          if (pos_r < HDR_CRC_LEN) begin
            crc_nxt = crc_byte(crc_r, b);
          end
          if (pos_r < HP_VER) begin
            hbad_nxt = hbad_nxt | (b != JRNL_MAGIC[{pos_r[2:0], 3'b000} +: 8]);
          end else if (pos_r == HP_VER) begin
            hbad_nxt = hbad_nxt | (b != HDR_VERSION);
          end else if (pos_r < HP_CAP) begin
            hbad_nxt = hbad_nxt | (b != 8'd0);
          end else if (pos_r < HP_CFG) begin
            // only 20 bits are kept; anything above makes the capacity too large
            if (cap_idx == 6'd0) begin
              cap_nxt[7:0] = b;
            end else if (cap_idx == 6'd1) begin
              cap_nxt[15:8] = b;
            end else if (cap_idx == 6'd2) begin
              cap_nxt[19:16] = b[3:0];
              cap_hi_nxt     = cap_hi_nxt | (b[7:4] != 4'd0);
            end else begin
              cap_hi_nxt = cap_hi_nxt | (b != 8'd0);
            end
          end else if (pos_r < HDR_CRC_LEN) begin
            acct_nxt[{pos_r[2:0] - HP_CFG[2:0], 3'b000} +: 8] = b;
          end else begin
            hbad_nxt = hbad_nxt | (b != crc_out[{pos_r[1:0], 3'b000} +: 8]);
          end
          pos_nxt = pos_inc;

          if (pos_r == HP_LAST) begin
            if (hbad_nxt) begin
              err = ERR_BAD_HDR;
            end else if (cap_bad) begin
              err = ERR_BAD_CAP;
            end else begin
              main_vld         = 1'b1;
              main_res.kind    = RK_HEADER;
              main_res.account = acct_r;
              main_res.capacity = cap_r;
              phase_nxt        = PH_RECORD;
              pos_nxt          = '0;
              crc_nxt          = CRC_INIT;
            end
          end else if (in_end_of_stream) begin
            err = ERR_SHORT_HDR;
          end
        end

        PH_RECORD: begin
          if (pos_r == '0) begin
            seqbad_nxt = 1'b0;
            encbad_nxt = 1'b0;
            crcbad_nxt = 1'b0;
          end
          if (pos_r < REC_CRC_LEN) begin
            crc_nxt = crc_byte(crc_r, b);
          end
          if (pos_r < RP_ACCT) begin
            seqbad_nxt = seqbad_nxt | (b != good_inc[{pos_r[2:0], 3'b000} +: 8]);
          end else if (pos_r < RP_CSEQ) begin
            acct_nxt[{pos_r[2:0], 3'b000} +: 8] = b;
          end else if (pos_r < RP_KIND) begin
            cseq_nxt[{pos_r[2:0], 3'b000} +: 8] = b;
          end else if (pos_r == RP_KIND) begin
            kind_nxt   = b[2:0];
            encbad_nxt = encbad_nxt | (b < KIND_MIN) | (b > KIND_MAX);
          end else if (pos_r == RP_SIDE) begin
            side_nxt   = b[1:0];
            encbad_nxt = encbad_nxt | !((b == SIDE_BUY) || (b == SIDE_SELL));
          end else if (pos_r < RP_ORDER) begin
            encbad_nxt = encbad_nxt | (b != 8'd0);
          end else if (pos_r < RP_PRICE) begin
            order_nxt[{pos_r[2:0], 3'b000} +: 8] = b;
          end else if (pos_r < RP_QTY) begin
            price_nxt[{pos_r[2:0], 3'b000} +: 8] = b;
          end else if (pos_r < REC_CRC_LEN) begin
            qty_nxt[{pos_r[2:0], 3'b000} +: 8] = b;
          end else begin
            crcbad_nxt = crcbad_nxt | (b != crc_out[{pos_r[1:0], 3'b000} +: 8]);
          end
          pos_nxt = pos_inc;

          if (pos_r == RP_LAST) begin
            pos_nxt = '0;
            crc_nxt = CRC_INIT;
            if (crcbad_nxt) begin
              err = ERR_REC_CRC;
            end else if (seqbad_nxt) begin
              err = ERR_SEQ_GAP;
            end else if (encbad_nxt) begin
              err = ERR_BAD_ENCODE;
            end else begin
              good_nxt                 = good_inc;
              main_vld                 = 1'b1;
              main_res.kind            = RK_RECORD;
              main_res.record_number   = good_inc;
              main_res.account         = acct_r;
              main_res.client_sequence = cseq_r;
              main_res.command_kind    = kind_r;
              main_res.command_side    = side_r;
              main_res.order_id        = order_r;
              main_res.price_bits      = price_r;
              main_res.quantity        = qty_r;
            end
          end
        end

        default: begin
          do_restart = 1'b1;
        end
      endcase

      if (err != ERR_NONE) begin
        tail_vld               = 1'b1;
        tail_res.kind          = RK_ERROR;
        tail_res.err           = err;
        tail_res.record_number = good_r;
        if (in_end_of_stream) begin
          do_restart = 1'b1;
        end else begin
          phase_nxt = PH_DROP;
        end
      end else if (in_end_of_stream && (phase_r == PH_HEADER || phase_r == PH_RECORD)) begin
        tail_vld               = 1'b1;
        tail_res.kind          = RK_SUMMARY;
        tail_res.record_number = good_nxt;
        tail_res.tail_bytes    = (phase_nxt == PH_RECORD) ? pos_nxt : 6'd0;
        do_restart             = 1'b1;
      end

      if (do_restart) begin
        phase_nxt = PH_HEADER;
        pos_nxt   = '0;
        crc_nxt   = CRC_INIT;
        good_nxt  = '0;
      end
    end
  end

  // queue pushes: the main result first, then the error or end summary
  assign res0   = main_vld ? main_res : tail_res;
  assign res1   = tail_res;
  assign n_push = {1'b0, main_vld} + {1'b0, tail_vld};
  assign wr0    = q_add(head_r, count_r);
  assign wr1    = q_add(wr0, 2'd1);

  assign head_nxt  = pop ? q_add(head_r, 2'd1) : head_r;
  assign count_nxt = count_r + n_push - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
      crc_r   <= CRC_INIT;
      good_r  <= '0;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
      good_r  <= good_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acct_r   <= acct_nxt;
    cseq_r   <= cseq_nxt;
    order_r  <= order_nxt;
    price_r  <= price_nxt;
    qty_r    <= qty_nxt;
    kind_r   <= kind_nxt;
    side_r   <= side_nxt;
    cap_r    <= cap_nxt;
    cap_hi_r <= cap_hi_nxt;
    hbad_r   <= hbad_nxt;
    seqbad_r <= seqbad_nxt;
    encbad_r <= encbad_nxt;
    crcbad_r <= crcbad_nxt;
    if (n_push != 2'd0) begin
      q_r[wr0] <= res0;
    end
    if (n_push == 2'd2) begin
      q_r[wr1] <= res1;
    end
  end

  assign head_res             = q_r[head_r];
  assign out_result_kind      = head_res.kind;
  assign out_error_code       = head_res.err;
  assign out_record_number    = head_res.record_number;
  assign out_account          = head_res.account;
  assign out_client_sequence  = head_res.client_sequence;
  assign out_command_kind     = head_res.command_kind;
  assign out_command_side     = head_res.command_side;
  assign out_order_id         = head_res.order_id;
  assign out_price_bits       = head_res.price_bits;
  assign out_quantity         = head_res.quantity;
  assign out_journal_capacity = head_res.capacity;
  assign out_tail_bytes       = head_res.tail_bytes;

  a_hdr_no_records: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEADER |-> good_r == '0)
    else $error("record count nonzero during header");

  a_hdr_pos: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEADER |-> pos_r < HDR_LEN)
    else $error("header position out of range");

  a_rec_pos: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_RECORD |-> pos_r < REC_LEN)
    else $error("record position out of range");

  a_crc_start: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_DROP && pos_r == '0) |-> crc_r == CRC_INIT)
    else $error("crc not reseeded at start of header or record");

  a_eos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_end_of_stream) |=> (phase_r == PH_HEADER && pos_r == '0 && good_r == '0))
    else $error("no restart after final byte");

endmodule

### test/testbench.sv
//------------------------------------------------------------------------------
// testbench
// Self-checking bench for the journal record stream checker core.
//------------------------------------------------------------------------------
// Builds journals byte by byte: good and damaged headers, records with every
// kind, side and fault, and truncated tails. Each accepted byte feeds a local
// model of the checker, and the model's results are queued. Each result on
// the output channel is compared field by field with the oldest queued one.
// The random part runs in phases with sender gaps and receiver stalls.
//------------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import jrsc_pkg::*;

  localparam int WD_LIMIT = 4000;

  typedef enum {HDR_OK, HDR_BAD_MAGIC, HDR_BAD_VER, HDR_BAD_CRC} hdr_fault_t;
  typedef enum {REC_OK, REC_BAD_CRC, REC_BAD_SEQ, REC_BAD_KIND, REC_BAD_SIDE,
                REC_BAD_PAD} rec_fault_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_end_of_stream = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_result_kind;
  logic [2:0]  out_error_code;
  logic [63:0] out_record_number;
  logic [63:0] out_account;
  logic [63:0] out_client_sequence;
  logic [2:0]  out_command_kind;
  logic [1:0]  out_command_side;
  logic [63:0] out_order_id;
  logic [63:0] out_price_bits;
  logic [63:0] out_quantity;
  logic [19:0] out_journal_capacity;
  logic [5:0]  out_tail_bytes;

  journal_record_stream_checker_core u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_data_byte         (in_data_byte),
    .in_end_of_stream     (in_end_of_stream),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_result_kind      (out_result_kind),
    .out_error_code       (out_error_code),
    .out_record_number    (out_record_number),
    .out_account          (out_account),
    .out_client_sequence  (out_client_sequence),
    .out_command_kind     (out_command_kind),
    .out_command_side     (out_command_side),
    .out_order_id         (out_order_id),
    .out_price_bits       (out_price_bits),
    .out_quantity         (out_quantity),
    .out_journal_capacity (out_journal_capacity),
    .out_tail_bytes       (out_tail_bytes)
  );

  always #4 clk = ~clk;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned n_fail = 0;
  int unsigned n_shown = 0;
  int unsigned n_live = 0;
  int unsigned n_predicted = 0;
  int unsigned wd_count = 0;

  res_t       awaited_results[$];
  logic [7:0] journal_bytes[$];

  // model state
  phase_t      jp_phase;
  logic [5:0]  jp_pos;
  logic [31:0] jp_crc;
  logic [63:0] jp_good;
  logic [7:0]  jp_buf[60];

  function automatic logic [31:0] crc32_update(logic [31:0] c, logic [7:0] b);
    logic [31:0] v;
    v = c;
    for (int i = 0; i < 8; i++) begin
      if (v[0] ^ b[i]) v = (v >> 1) ^ 32'hedb8_8320;
      else v = v >> 1;
    end
    return v;
  endfunction

  function automatic logic [63:0] buf_le(int off, int len);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < len; i++) v[8*i +: 8] = jp_buf[off + i];
    return v;
  endfunction

  function automatic void jrnl_restart();
    jp_phase = PH_HEADER;
    jp_pos   = 6'd0;
    jp_crc   = 32'hffff_ffff;
    jp_good  = 64'd0;
  endfunction

  function automatic void expect_result(res_t r);
    awaited_results.push_back(r);
    n_predicted++;
  endfunction

  task automatic track_journal_byte(input logic [7:0] b, input logic eos);
    res_t        r;
    err_code_t   err;
    logic [63:0] cap;
    logic [7:0]  kind;
    logic [7:0]  side;
    err = ERR_NONE;
    if (jp_phase == PH_DROP) begin
      if (eos) jrnl_restart();
      return;
    end
    if (jp_pos >= 6'd60) jp_pos = 6'd0;
    jp_buf[jp_pos] = b;
    if (jp_phase == PH_HEADER) begin
      if (jp_pos < 6'd28) jp_crc = crc32_update(jp_crc, b);
      jp_pos++;
      if (jp_pos >= 6'd32) begin
        cap = buf_le(12, 8);
        if (buf_le(0, 8) != JRNL_MAGIC || buf_le(8, 4) != 64'd2 ||
            buf_le(28, 4) != {32'd0, ~jp_crc})
          err = ERR_BAD_HDR;
        else if (cap == 64'd0 || cap > 64'd1000000)
          err = ERR_BAD_CAP;
        else begin
          r = '0;
          r.kind     = RK_HEADER;
          r.err      = ERR_NONE;
          r.account  = buf_le(20, 8);
          r.capacity = cap[19:0];
          expect_result(r);
          jp_phase = PH_RECORD;
          jp_pos   = 6'd0;
          jp_crc   = 32'hffff_ffff;
        end
      end else if (eos) begin
        err = ERR_SHORT_HDR;
      end
    end else begin
      if (jp_pos < 6'd56) jp_crc = crc32_update(jp_crc, b);
      jp_pos++;
      if (jp_pos >= 6'd60) begin
        kind = jp_buf[24];
        side = jp_buf[25];
        if (buf_le(56, 4) != {32'd0, ~jp_crc})
          err = ERR_REC_CRC;
        else if (buf_le(0, 8) != jp_good + 64'd1)
          err = ERR_SEQ_GAP;
        else if (kind < 8'd1 || kind > 8'd4 || (side != 8'd1 && side != 8'd2) ||
                 buf_le(26, 6) != 64'd0)
          err = ERR_BAD_ENCODE;
        else begin
          jp_good++;
          r = '0;
          r.kind            = RK_RECORD;
          r.err             = ERR_NONE;
          r.record_number   = jp_good;
          r.account         = buf_le(8, 8);
          r.client_sequence = buf_le(16, 8);
          r.command_kind    = kind[2:0];
          r.command_side    = side[1:0];
          r.order_id        = buf_le(32, 8);
          r.price_bits      = buf_le(40, 8);
          r.quantity        = buf_le(48, 8);
          expect_result(r);
        end
        jp_pos = 6'd0;
        jp_crc = 32'hffff_ffff;
      end
    end

    if (err != ERR_NONE) begin
      r = '0;
      r.kind          = RK_ERROR;
      r.err           = err;
      r.record_number = jp_good;
      expect_result(r);
      if (eos) jrnl_restart();
      else jp_phase = PH_DROP;
      return;
    end
    if (eos) begin
      r = '0;
      r.kind          = RK_SUMMARY;
      r.err           = ERR_NONE;
      r.record_number = jp_good;
      r.tail_bytes    = (jp_phase == PH_RECORD) ? jp_pos : 6'd0;
      expect_result(r);
      jrnl_restart();
    end
  endtask

  // ---------------------------------------------------------------- journal build

  function automatic logic [63:0] rand_word();
    case ($urandom_range(9))
      0: return 64'd0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] pick_capacity();
    case ($urandom_range(9))
      0: return 64'd1;
      1: return 64'd1000000;
      default: return 64'($urandom_range(1000000, 1));
    endcase
  endfunction

  function automatic logic [63:0] pick_bad_capacity();
    case ($urandom_range(2))
      0: return 64'd0;
      1: return 64'd1000001;
      default: return {$urandom, $urandom} | (64'd1 << (20 + $urandom_range(43)));
    endcase
  endfunction

  function automatic void add_header(logic [63:0] cap, logic [63:0] cfg,
                                     hdr_fault_t fault);
    logic [7:0]  h[32];
    logic [31:0] ver;
    logic [31:0] c;
    for (int i = 0; i < 8; i++) h[i] = JRNL_MAGIC[8*i +: 8];
    ver = 32'd2;
    if (fault == HDR_BAD_VER) ver = ver ^ (32'd1 << $urandom_range(31));
    for (int i = 0; i < 4; i++) h[8 + i] = ver[8*i +: 8];
    for (int i = 0; i < 8; i++) h[12 + i] = cap[8*i +: 8];
    for (int i = 0; i < 8; i++) h[20 + i] = cfg[8*i +: 8];
    if (fault == HDR_BAD_MAGIC)
      h[$urandom_range(7)] ^= 8'd1 << $urandom_range(7);
    c = 32'hffff_ffff;
    for (int i = 0; i < 28; i++) c = crc32_update(c, h[i]);
    c = ~c;
    if (fault == HDR_BAD_CRC) c ^= 32'd1 << $urandom_range(31);
    for (int i = 0; i < 4; i++) h[28 + i] = c[8*i +: 8];
    for (int i = 0; i < 32; i++) journal_bytes.push_back(h[i]);
  endfunction

  function automatic void add_record(logic [63:0] seq, logic [63:0] acct,
                                     logic [63:0] cseq, logic [7:0] kind,
                                     logic [7:0] side, logic [47:0] pad,
                                     logic [63:0] order, logic [63:0] price,
                                     logic [63:0] qty, bit bad_crc);
    logic [7:0]  r[60];
    logic [31:0] c;
    for (int i = 0; i < 8; i++) begin
      r[i]      = seq[8*i +: 8];
      r[8 + i]  = acct[8*i +: 8];
      r[16 + i] = cseq[8*i +: 8];
      r[32 + i] = order[8*i +: 8];
      r[40 + i] = price[8*i +: 8];
      r[48 + i] = qty[8*i +: 8];
    end
    r[24] = kind;
    r[25] = side;
    for (int i = 0; i < 6; i++) r[26 + i] = pad[8*i +: 8];
    c = 32'hffff_ffff;
    for (int i = 0; i < 56; i++) c = crc32_update(c, r[i]);
    c = ~c;
    if (bad_crc) c ^= 32'd1 << $urandom_range(31);
    for (int i = 0; i < 4; i++) r[56 + i] = c[8*i +: 8];
    for (int i = 0; i < 60; i++) journal_bytes.push_back(r[i]);
  endfunction

  function automatic void add_random_record(logic [63:0] seq, rec_fault_t fault);
    logic [7:0]  kind;
    logic [7:0]  side;
    logic [47:0] pad;
    logic [63:0] s;
    bit          bad_crc;
    kind    = 8'($urandom_range(4, 1));
    side    = 8'($urandom_range(2, 1));
    pad     = '0;
    s       = seq;
    bad_crc = 1'b0;
    case (fault)
      REC_BAD_CRC:  bad_crc = 1'b1;
      REC_BAD_SEQ:  s = seq ^ ({$urandom, $urandom} | 64'd1);
      REC_BAD_KIND: kind = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, 5));
      REC_BAD_SIDE: side = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, 3));
      REC_BAD_PAD: begin
        pad = 48'({$urandom, $urandom});
        pad[$urandom_range(47)] = 1'b1;
      end
      default: ;
    endcase
    add_record(s, rand_word(), rand_word(), kind, side, pad,
               rand_word(), rand_word(), rand_word(), bad_crc);
  endfunction

  function automatic void add_noise(int n);
    repeat (n) journal_bytes.push_back(8'($urandom));
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic send_item(input logic [7:0] b, input logic eos);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_end_of_stream <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (jp_phase != PH_DROP) n_live++;
    track_journal_byte(b, eos);
    @(negedge clk);
  endtask

  task automatic send_journal();
    for (int i = 0; i < journal_bytes.size(); i++)
      send_item(journal_bytes[i], i == journal_bytes.size() - 1);
    journal_bytes.delete();
  endtask

  always @(negedge clk)
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

  // ---------------------------------------------------------------- checking

  task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    n_fail++;
    if (n_shown < 10) begin
      n_shown++;
      $display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
    end
  endtask

  task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) note_mismatch(what, want, got);
  endtask

  always @(posedge clk) begin
    res_t r;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        note_mismatch("unexpected result, kind", 64'd0, 64'(out_result_kind));
      end else begin
        r = awaited_results.pop_front();
        check_field("result_kind", 64'(r.kind), 64'(out_result_kind));
        check_field("error_code", 64'(r.err), 64'(out_error_code));
        check_field("record_number", r.record_number, out_record_number);
        check_field("account", r.account, out_account);
        check_field("client_sequence", r.client_sequence, out_client_sequence);
        check_field("command_kind", 64'(r.command_kind), 64'(out_command_kind));
        check_field("command_side", 64'(r.command_side), 64'(out_command_side));
        check_field("order_id", r.order_id, out_order_id);
        check_field("price_bits", r.price_bits, out_price_bits);
        check_field("quantity", r.quantity, out_quantity);
        check_field("journal_capacity", 64'(r.capacity), 64'(out_journal_capacity));
        check_field("tail_bytes", 64'(r.tail_bytes), 64'(out_tail_bytes));
      end
    end
  end

  // watchdog: cycles with no item moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      wd_count <= 0;
    end else begin
      wd_count <= wd_count + 1;
      if (wd_count >= WD_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_header_checks();
    // header ending on the final byte: header then an empty summary
    add_header(64'd1, 64'd0, HDR_OK);
    send_journal();
    // widest capacity, one record closing the stream
    add_header(64'd1000000, '1, HDR_OK);
    add_random_record(64'd1, REC_OK);
    send_journal();
    // short headers: a lone byte, then 31 bytes
    journal_bytes.push_back(8'hff);
    send_journal();
    add_header(pick_capacity(), rand_word(), HDR_OK);
    void'(journal_bytes.pop_back());
    send_journal();
    // bad magic wins over bad capacity; trailing bytes are dropped
    add_header(64'd0, rand_word(), HDR_BAD_MAGIC);
    add_noise(3);
    send_journal();
    add_header(pick_capacity(), rand_word(), HDR_BAD_VER);
    send_journal();
    add_header(pick_capacity(), rand_word(), HDR_BAD_CRC);
    add_noise(1);
    send_journal();
    add_header(64'd0, rand_word(), HDR_OK);
    send_journal();
    add_header(64'd1000001, rand_word(), HDR_OK);
    add_noise(2);
    send_journal();
    add_header((64'd1 << 40) | 64'd5, rand_word(), HDR_OK);
    send_journal();
  endtask

  task automatic test_record_checks();
    add_header(pick_capacity(), rand_word(), HDR_OK);
    add_record(64'd1, '0, '0, 8'd1, 8'd1, '0, '0, '0, '0, 1'b0);
    add_record(64'd2, '1, '1, 8'd4, 8'd2, '0, '1, '1, '1, 1'b0);
    add_noise(59);
    send_journal();
    // each record fault on the first record, then dropped bytes
    for (int f = REC_BAD_CRC; f <= REC_BAD_PAD; f++) begin
      add_header(pick_capacity(), rand_word(), HDR_OK);
      add_random_record(64'd1, rec_fault_t'(f));
      add_noise(2);
      send_journal();
    end
    // kind and side just above range, each on the final byte
    add_header(pick_capacity(), rand_word(), HDR_OK);
    add_record(64'd1, '0, '0, 8'd5, 8'd2, '0, '0, '0, '0, 1'b0);
    send_journal();
    add_header(pick_capacity(), rand_word(), HDR_OK);
    add_record(64'd1, '0, '0, 8'd3, 8'd3, '0, '0, '0, '0, 1'b0);
    send_journal();
    // bad CRC and bad sequence together report the CRC, after one good record
    add_header(pick_capacity(), rand_word(), HDR_OK);
    add_random_record(64'd1, REC_OK);
    add_record(64'd9, '1, '1, 8'd1, 8'd2, '0, '1, '1, '1, 1'b1);
    add_noise(4);
    send_journal();
  endtask

  task automatic run_random_journal();
    int unsigned sel;
    int unsigned n_rec;
    sel = $urandom_range(99);
    if (sel < 8) begin
      add_noise($urandom_range(40, 1));
    end else if (sel < 16) begin
      if ($urandom_range(3) == 0)
        add_header(pick_bad_capacity(), rand_word(), HDR_OK);
      else
        add_header(pick_capacity(), rand_word(),
                   hdr_fault_t'($urandom_range(HDR_BAD_CRC, HDR_BAD_MAGIC)));
      add_noise($urandom_range(6, 0));
    end else begin
      add_header(pick_capacity(), rand_word(), HDR_OK);
      n_rec = $urandom_range(2, 0);
      for (int k = 1; k <= n_rec; k++) add_random_record(64'(k), REC_OK);
      case ($urandom_range(9))
        0, 1: begin
          add_random_record(64'(n_rec + 1),
                            rec_fault_t'($urandom_range(REC_BAD_PAD, REC_BAD_CRC)));
          add_noise($urandom_range(4, 0));
        end
        2, 3, 4: add_noise($urandom_range(59, 1));
        default: ;
      endcase
    end
    send_journal();
  endtask

  task automatic test_random_traffic();
    int unsigned gap_tab[4]   = '{0, 52, 0, 38};
    int unsigned stall_tab[4] = '{0, 0, 52, 38};
    int unsigned live0;
    int unsigned pred0;
    // the directed tests run in the no-idling phase
    for (int p = 1; p < 4; p++) begin
      idle_pct  = gap_tab[p];
      stall_pct = stall_tab[p];
      live0 = n_live;
      pred0 = n_predicted;
      while (n_live < live0 + 40 || n_predicted < pred0 + 3)
        run_random_journal();
    end
  endtask

  initial begin
    jrnl_restart();
    for (int i = 0; i < 60; i++) jp_buf[i] = 8'h00;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_header_checks();
    test_record_checks();
    test_random_traffic();

    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (n_fail == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

### journal_record_stream_checker_core.f
rtl/core/jrsc_pkg.sv
rtl/core/journal_record_stream_checker_core.sv
test/testbench.sv
